// ----- src/etfp_pkg.sv -----
// Shared types, register indexes and helpers for the escape-time fractal pixel unit.
package etfp_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_PIXEL_STEP   = 3'd0;
    localparam logic [2:0] CFG_CENTER_TWICE = 3'd1;
    localparam logic [2:0] CFG_PAN_RE       = 3'd2;
    localparam logic [2:0] CFG_PAN_IM       = 3'd3;
    localparam logic [2:0] CFG_MANDEL_MODE  = 3'd4;
    localparam logic [2:0] CFG_JULIA_C_RE   = 3'd5;
    localparam logic [2:0] CFG_JULIA_C_IM   = 3'd6;

    // Colour packing
    localparam logic [31:0] COLOR_BASE = 32'h00FF_0080;
    localparam logic [31:0] COLOR_STEP = 32'd100000;

    typedef struct packed {
        logic [30:0]        pixel_step;
        logic [12:0]        center_twice;
        logic signed [31:0] pan_re;
        logic signed [31:0] pan_im;
        logic               mandel_mode;
        logic signed [31:0] julia_c_re;
        logic signed [31:0] julia_c_im;
    } t_cfg;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MAP_MUL,
        OP_MAP_ADD,
        OP_IT_MUL,
        OP_IT_UPD
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic finish;
    } t_dp_sts;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v[65:31] == {35{1'b0}} || v[65:31] == {35{1'b1}}) begin
            r = v[31:0];
        end else if (v[65]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

// ----- src/etfp_ctrl.sv -----
// Controller state machine sequencing mapping, iteration and result hand-off.
module etfp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  etfp_pkg::t_dp_sts i_sts,
    output etfp_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP_MUL,
        ST_MAP_ADD,
        ST_IT_MUL,
        ST_IT_UPD,
        ST_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;
    logic   w_in_take;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_in_take   = (r_state == ST_IDLE) && i_in_valid;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    // Decode next state and datapath command
    always_comb begin
        n_state         = r_state;
        o_cmd.op        = etfp_pkg::OP_NONE;
        o_cmd.out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_take) begin
                    o_cmd.op = etfp_pkg::OP_LOAD;
                    n_state  = ST_MAP_MUL;
                end
            end
            ST_MAP_MUL: begin
                o_cmd.op = etfp_pkg::OP_MAP_MUL;
                n_state  = ST_MAP_ADD;
            end
            ST_MAP_ADD: begin
                o_cmd.op = etfp_pkg::OP_MAP_ADD;
                n_state  = ST_IT_MUL;
            end
            ST_IT_MUL: begin
                o_cmd.op = etfp_pkg::OP_IT_MUL;
                n_state  = ST_IT_UPD;
            end
            ST_IT_UPD: begin
                if (!i_sts.finish) begin
                    o_cmd.op = etfp_pkg::OP_IT_UPD;
                    n_state  = ST_IT_MUL;
                end else if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Set valid on a fresh result, drop it once the word is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- src/etfp_dpath.sv -----
// Datapath: coordinate mapping, complex squaring with saturation and result register.
module etfp_dpath #(
    parameter int MAX_ITERATIONS = 100,
    parameter int FRAC_BITS      = 27
) (
    input  logic              i_clk,
    input  etfp_pkg::t_cfg    i_cfg,
    input  etfp_pkg::t_dp_cmd i_cmd,
    output etfp_pkg::t_dp_sts o_sts,
    input  logic [9:0]        i_pixel_x,
    input  logic [9:0]        i_pixel_y,
    output logic [6:0]        o_iteration_count,
    output logic [24:0]       o_pixel_color
);

    localparam int CNT_W = $clog2(MAX_ITERATIONS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITERATIONS);
    localparam logic [64:0] ESC_LIMIT = 65'(4) << (2 * FRAC_BITS);

    logic [9:0]         r_px;
    logic [9:0]         r_py;
    logic signed [31:0] r_re;
    logic signed [31:0] r_im;
    logic signed [31:0] r_cre;
    logic signed [31:0] r_cim;
    logic [CNT_W-1:0]   r_count;
    logic signed [63:0] r_p0;
    logic signed [63:0] r_p1;
    logic signed [63:0] r_p2;
    logic [6:0]         r_iteration_count;
    logic [24:0]        r_pixel_color;

    logic               w_map;
    logic signed [13:0] w_dx;
    logic signed [13:0] w_dy;
    logic signed [31:0] w_step;
    logic signed [31:0] w_a0;
    logic signed [31:0] w_b0;
    logic signed [31:0] w_a1;
    logic signed [31:0] w_b1;
    logic signed [63:0] w_m0;
    logic signed [63:0] w_m1;
    logic signed [63:0] w_m2;
    logic signed [31:0] w_map_re;
    logic signed [31:0] w_map_im;
    logic signed [31:0] w_nre;
    logic signed [31:0] w_nim;
    logic [64:0]        w_mag;
    logic               w_escape;
    logic [CNT_W+6:0]   w_count_ext;
    logic [31:0]        w_color;

    // Offsets from the view centre, in half pixels
    assign w_dx   = $signed({3'b000, r_px, 1'b0}) - $signed({1'b0, i_cfg.center_twice});
    assign w_dy   = $signed({3'b000, r_py, 1'b0}) - $signed({1'b0, i_cfg.center_twice});
    assign w_step = $signed({1'b0, i_cfg.pixel_step});

    // Share the multiplier bank between mapping and squaring
    assign w_map = (i_cmd.op == etfp_pkg::OP_MAP_MUL);
    assign w_a0  = w_map ? w_step : r_re;
    assign w_b0  = w_map ? 32'(w_dx) : r_re;
    assign w_a1  = w_map ? w_step : r_im;
    assign w_b1  = w_map ? 32'(w_dy) : r_im;
    assign w_m0  = w_a0 * w_b0;
    assign w_m1  = w_a1 * w_b1;
    assign w_m2  = r_re * r_im;

    // Halve the scaled offset and add the pan
    assign w_map_re = etfp_pkg::sat32(66'(r_p0 >>> 1) + 66'(i_cfg.pan_re));
    assign w_map_im = etfp_pkg::sat32(66'(r_p1 >>> 1) + 66'(i_cfg.pan_im));

    // Next z from the registered products
    assign w_nre = etfp_pkg::sat32(66'(r_p0 >>> FRAC_BITS) - 66'(r_p1 >>> FRAC_BITS)
                                   + 66'(r_cre));
    assign w_nim = etfp_pkg::sat32(66'(r_p2 >>> (FRAC_BITS - 1)) + 66'(r_cim));

    // Escape on |z|^2 > 4 or on reaching the iteration limit
    assign w_mag      = {1'b0, $unsigned(r_p0)} + {1'b0, $unsigned(r_p1)};
    assign w_escape   = (w_mag > ESC_LIMIT);
    assign o_sts.finish = w_escape || (r_count >= CNT_MAX);

    // Pack the result
    assign w_count_ext = {7'b0, r_count};
    assign w_color     = etfp_pkg::COLOR_BASE + 32'(r_count) * etfp_pkg::COLOR_STEP;

    // Advance the working registers on each command
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            etfp_pkg::OP_LOAD: begin
                r_px <= i_pixel_x;
                r_py <= i_pixel_y;
            end
            etfp_pkg::OP_MAP_MUL: begin
                r_p0 <= w_m0;
                r_p1 <= w_m1;
            end
            etfp_pkg::OP_MAP_ADD: begin
                r_re    <= w_map_re;
                r_im    <= w_map_im;
                r_cre   <= i_cfg.mandel_mode ? w_map_re : i_cfg.julia_c_re;
                r_cim   <= i_cfg.mandel_mode ? w_map_im : i_cfg.julia_c_im;
                r_count <= CNT_W'(1);
            end
            etfp_pkg::OP_IT_MUL: begin
                r_p0 <= w_m0;
                r_p1 <= w_m1;
                r_p2 <= w_m2;
            end
            etfp_pkg::OP_IT_UPD: begin
                r_re    <= w_nre;
                r_im    <= w_nim;
                r_count <= r_count + CNT_W'(1);
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_iteration_count <= w_count_ext[6:0];
            r_pixel_color     <= w_color[24:0];
        end
    end

    assign o_iteration_count = r_iteration_count;
    assign o_pixel_color     = r_pixel_color;

endmodule

// ----- src/escape_time_fractal_pixel_unit.sv -----
// Top level: configuration registers, controller and datapath of the fractal pixel unit.
//
// Takes one pixel coordinate per word, maps it to a point of the complex plane
// (pixel_step * (pixel - centre) + pan, Q5.27) and iterates z = z^2 + c in
// Mandelbrot or Julia mode, returning the iteration count and a packed colour.
// The coordinate is mapped in two steps, a scaling product and then the halving
// and pan; then each pass of the loop runs the three 32x32 multipliers and then
// the escape test and the saturating update, until escape or MAX_ITERATIONS.
// A new pixel is taken only once the previous one has finished; the finished
// result sits in an output register, so the next pixel starts while that word
// waits to be taken. Configuration is to be written through the plain write port
// only while the unit idles; the block itself does not enforce this.
module escape_time_fractal_pixel_unit #(
    parameter int MAX_ITERATIONS = 100,
    parameter int SCREEN_SIZE    = 1024,
    parameter int FRAC_BITS      = 27
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [9:0]  i_pixel_x,
    input  logic [9:0]  i_pixel_y,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [6:0]  o_iteration_count,
    output logic [24:0] o_pixel_color
);

    localparam logic [63:0] STEP_DEN   = 64'(SCREEN_SIZE - 1);
    localparam logic [63:0] STEP_NUM   = 64'(4) << (FRAC_BITS + 1);
    localparam logic [63:0] STEP_RESET = (STEP_NUM + STEP_DEN) / (64'(2) * STEP_DEN);

    etfp_pkg::t_cfg    r_cfg;
    etfp_pkg::t_dp_cmd w_cmd;
    etfp_pkg::t_dp_sts w_sts;

    // Write the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_step   <= STEP_RESET[30:0];
            r_cfg.center_twice <= STEP_DEN[12:0];
            r_cfg.pan_re       <= '0;
            r_cfg.pan_im       <= '0;
            r_cfg.mandel_mode  <= 1'b1;
            r_cfg.julia_c_re   <= '0;
            r_cfg.julia_c_im   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                etfp_pkg::CFG_PIXEL_STEP:   r_cfg.pixel_step   <= i_cfg_data[30:0];
                etfp_pkg::CFG_CENTER_TWICE: r_cfg.center_twice <= i_cfg_data[12:0];
                etfp_pkg::CFG_PAN_RE:       r_cfg.pan_re       <= i_cfg_data;
                etfp_pkg::CFG_PAN_IM:       r_cfg.pan_im       <= i_cfg_data;
                etfp_pkg::CFG_MANDEL_MODE:  r_cfg.mandel_mode  <= i_cfg_data[0];
                etfp_pkg::CFG_JULIA_C_RE:   r_cfg.julia_c_re   <= i_cfg_data;
                etfp_pkg::CFG_JULIA_C_IM:   r_cfg.julia_c_im   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    etfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    etfp_dpath #(
        .MAX_ITERATIONS (MAX_ITERATIONS),
        .FRAC_BITS      (FRAC_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_cfg             (r_cfg),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_pixel_x         (i_pixel_x),
        .i_pixel_y         (i_pixel_y),
        .o_iteration_count (o_iteration_count),
        .o_pixel_color     (o_pixel_color)
    );

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the escape-time fractal pixel unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ITERATIONS = 100;
    localparam int SCREEN_SIZE    = 1024;
    localparam int FRAC_BITS      = 27;

    localparam logic [30:0] RESET_STEP = 31'(((64'd4 << (FRAC_BITS + 1)) + (SCREEN_SIZE - 1))
                                             / (2 * (SCREEN_SIZE - 1)));
    localparam logic [12:0] RESET_CENTER = 13'(SCREEN_SIZE - 1);

    // Index that decodes to no register
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;
    localparam logic signed [64:0] ESCAPE_LIMIT = 65'sd4 << (2 * FRAC_BITS);

    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_PIXELS   = 67;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int TAIL_CYCLES    = 2 * MAX_ITERATIONS + 50;

    typedef struct packed {
        logic [6:0]  count;
        logic [24:0] color;
    } t_escape_word;

    // Register copy, escape-time prediction and the queue of expected words
    class escape_tally;
        etfp_pkg::t_cfg regs;
        t_escape_word   expected_q[$];
        int             errors;

        function new();
            regs = '0;
            regs.pixel_step   = RESET_STEP;
            regs.center_twice = RESET_CENTER;
            regs.mandel_mode  = 1'b1;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                etfp_pkg::CFG_PIXEL_STEP:   regs.pixel_step   = data[30:0];
                etfp_pkg::CFG_CENTER_TWICE: regs.center_twice = data[12:0];
                etfp_pkg::CFG_PAN_RE:       regs.pan_re       = data;
                etfp_pkg::CFG_PAN_IM:       regs.pan_im       = data;
                etfp_pkg::CFG_MANDEL_MODE:  regs.mandel_mode  = data[0];
                etfp_pkg::CFG_JULIA_C_RE:   regs.julia_c_re   = data;
                etfp_pkg::CFG_JULIA_C_IM:   regs.julia_c_im   = data;
                default: ;
            endcase
        endfunction

        function logic signed [31:0] clamp_word(longint v);
            if (v > WORD_MAX) return 32'sh7FFF_FFFF;
            if (v < WORD_MIN) return 32'sh8000_0000;
            return v[31:0];
        endfunction

        // Map one pixel axis onto the plane: floor(step * (2*pix - centre2) / 2) + pan
        function logic signed [31:0] plane_coord(logic [9:0] pix, logic signed [31:0] pan);
            longint span;
            longint offset;
            span   = 2 * longint'(pix) - longint'(regs.center_twice);
            offset = (longint'(regs.pixel_step) * span) >>> 1;
            return clamp_word(offset + longint'(pan));
        endfunction

        function t_escape_word escape_word(logic [9:0] x, logic [9:0] y);
            longint       re, im, c_re, c_im, rr, ii, ri;
            int           count;
            t_escape_word w;
            re = plane_coord(x, $signed(regs.pan_re));
            im = plane_coord(y, $signed(regs.pan_im));
            c_re = regs.mandel_mode ? re : longint'($signed(regs.julia_c_re));
            c_im = regs.mandel_mode ? im : longint'($signed(regs.julia_c_im));
            count = 1;
            // Iterate z = z^2 + c until escape or the iteration cap
            while (count < MAX_ITERATIONS &&
                   (65'(re * re) + 65'(im * im)) <= ESCAPE_LIMIT) begin
                rr = (re * re) >>> FRAC_BITS;
                ii = (im * im) >>> FRAC_BITS;
                ri = (re * im) >>> (FRAC_BITS - 1);
                re = clamp_word(rr - ii + c_re);
                im = clamp_word(ri + c_im);
                count++;
            end
            w.count = 7'(count);
            w.color = 25'(etfp_pkg::COLOR_BASE + 32'(count) * etfp_pkg::COLOR_STEP);
            return w;
        endfunction

        function void note_pixel(logic [9:0] x, logic [9:0] y);
            expected_q.push_back(escape_word(x, y));
        endfunction

        function void check_pixel(logic [6:0] count, logic [24:0] color);
            t_escape_word w;
            if (expected_q.size() == 0) begin
                $error("result word with no pixel pending: iteration_count %0d pixel_color %0d",
                       count, color);
                errors++;
                return;
            end
            w = expected_q.pop_front();
            if (count !== w.count) begin
                $error("iteration_count: expected %0d, actual %0d", w.count, count);
                errors++;
            end
            if (color !== w.color) begin
                $error("pixel_color: expected %0d, actual %0d", w.color, color);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [9:0]  i_pixel_x;
    logic [9:0]  i_pixel_y;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [6:0]  o_iteration_count;
    logic [24:0] o_pixel_color;

    escape_tally tally;
    bit          calm;
    bit          squeeze_armed;

    escape_time_fractal_pixel_unit #(
        .MAX_ITERATIONS (MAX_ITERATIONS),
        .SCREEN_SIZE    (SCREEN_SIZE),
        .FRAC_BITS      (FRAC_BITS)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_pixel_x         (i_pixel_x),
        .i_pixel_y         (i_pixel_y),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_iteration_count (o_iteration_count),
        .o_pixel_color     (o_pixel_color)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm) return 0;
        if (roll < 45) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 90);
    endfunction

    function automatic logic [31:0] q27(input real v);
        return 32'($rtoi(v * 134217728.0));
    endfunction

    // Offer one pixel word and hold it until taken
    task automatic send_pixel(input logic [9:0] x, input logic [9:0] y);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_pixel_x  <= x;
        i_pixel_y  <= y;
        do @(posedge i_clk); while (o_in_stall);
        tally.note_pixel(x, y);
    endtask

    // Drop valid and wait until every pending pixel has come back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tally.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        tally.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_view(input logic [31:0] step, input logic [31:0] centre2,
                              input logic [31:0] pan_re, input logic [31:0] pan_im,
                              input logic [31:0] mode, input logic [31:0] c_re,
                              input logic [31:0] c_im);
        write_reg(etfp_pkg::CFG_PIXEL_STEP, step);
        write_reg(etfp_pkg::CFG_CENTER_TWICE, centre2);
        write_reg(etfp_pkg::CFG_PAN_RE, pan_re);
        write_reg(etfp_pkg::CFG_PAN_IM, pan_im);
        write_reg(etfp_pkg::CFG_MANDEL_MODE, mode);
        write_reg(etfp_pkg::CFG_JULIA_C_RE, c_re);
        write_reg(etfp_pkg::CFG_JULIA_C_IM, c_im);
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int hold_left;
        int free_left;
        hold_left = 0;
        free_left = 0;
        forever begin
            @(negedge i_clk);
            if (squeeze_armed) begin
                squeeze_armed = 1'b0;
                hold_left = SQUEEZE_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (free_left > 0 || calm) begin
                i_out_stall <= 1'b0;
                if (free_left > 0) free_left--;
            end else begin
                hold_left = pick_gap();
                free_left = $urandom_range(1, 16);
                i_out_stall <= (hold_left > 0);
                if (hold_left > 0) hold_left--;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tally.check_pixel(o_iteration_count, o_pixel_color);
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("escape_time_fractal_pixel_unit: mismatch");
        $finish;
    end

    initial begin : stimulus
        int          phase;
        int          k;
        int          spot;
        logic [31:0] near_step;
        tally = new();
        calm          = 1'b0;
        squeeze_armed = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_pixel_x   = '0;
        i_pixel_y   = '0;
        i_out_stall = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default view: corners escape at once, centre stays bounded
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd511, 10'd511);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd384, 10'd511);
        send_pixel(10'd700, 10'd300);
        send_pixel(10'd255, 10'd640);
        drain();

        // Zero step: every pixel lands on the origin and hits the cap
        apply_view(32'd0, 32'd1023, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        drain();

        // Widest step and pan extremes: mapping saturates both ways;
        // bits above each register's width and a dead index are dropped
        apply_view(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h1, 32'd0, 32'd0);
        write_reg(CFG_UNUSED, $urandom());
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        drain();
        write_reg(etfp_pkg::CFG_CENTER_TWICE, 32'd0);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1);
        drain();

        // Julia with extreme constants: the update saturates high then low
        apply_view(32'd0, 32'd1023, q27(1.9), q27(0.5), 32'hFFFF_FFFE,
                   32'h7FFF_FFFF, 32'h8000_0000);
        send_pixel(10'd5, 10'd5);
        drain();
        apply_view(32'd0, 32'd1023, q27(0.5), q27(1.9), 32'h0,
                   32'h8000_0000, 32'h7FFF_FFFF);
        send_pixel(10'd5, 10'd5);
        drain();

        // Random views, each with a run of random pixels
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            calm = (phase == 2 || phase == 5);
            near_step = 32'd474801 + $urandom_range(0, 100000);
            case (phase % 4)
                0: apply_view(near_step, 32'd959 + $urandom_range(0, 128),
                              q27(real'($urandom_range(0, 100)) / 100.0 - 0.5),
                              q27(real'($urandom_range(0, 100)) / 100.0 - 0.5),
                              $urandom() | 32'h1, $urandom(), $urandom());
                1: begin
                    spot = $urandom_range(0, 3);
                    apply_view(RESET_STEP >> $urandom_range(2, 7), 32'd1023,
                               q27(spot == 0 ? -0.75 : spot == 1 ? -1.25 :
                                   spot == 2 ? 0.28 : -0.1),
                               q27(spot == 0 ? 0.1 : spot == 1 ? 0.02 :
                                   spot == 2 ? 0.01 : 0.9),
                               32'h1, $urandom(), $urandom());
                end
                2: begin
                    spot = $urandom_range(0, 2);
                    apply_view(near_step, 32'd1023, 32'd0, 32'd0,
                               $urandom() & ~32'h1,
                               q27(spot == 0 ? -0.8 : spot == 1 ? 0.285 : -0.4),
                               q27(spot == 0 ? 0.156 : spot == 1 ? 0.01 : 0.6));
                end
                default: apply_view($urandom(), $urandom(), $urandom(), $urandom(),
                                    $urandom(), $urandom(), $urandom());
            endcase
            for (k = 0; k < PHASE_PIXELS; k++) begin
                if (phase == 0 && k == 3) squeeze_armed = 1'b1;
                send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
            end
            drain();
        end
        calm = 1'b0;

        // Let any stray word show up before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tally.errors == 0 && tally.pending() == 0) begin
            $display("escape_time_fractal_pixel_unit: match");
        end else begin
            $display("escape_time_fractal_pixel_unit: mismatch");
        end
        $finish;
    end

endmodule
